// ----- rtl/core/rdjd_pkg.sv -----
// shared types, constants and the month table of the day number to julian date converter
package rdjd_pkg;

    // 4*rdn + 7 shifted so that year -32768 starts at zero
    localparam int unsigned SCALE_OFFSET = 32'd47875516;
    // 65536 julian years of 1461 quarter days each
    localparam int unsigned SCALE_SPAN   = 32'd95748096;
    localparam int unsigned QUARTER_YEAR = 1461;
    // ceil(2**RECIP_SHIFT / 1461), exact for every in-range scaled value
    localparam int unsigned RECIP        = 32'd188143674;
    localparam int unsigned RECIP_SHIFT  = 38;

    localparam int SCALED_W = 27;
    localparam int RECIP_W  = 28;
    localparam int PROD_W   = SCALED_W + RECIP_W;
    localparam int QUOT_W   = 16;
    localparam int REM_W    = 11;

    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic                ok;
        logic [SCALED_W-1:0] scaled;
        logic [6:0]          wsum;
    } rdjd_s1_t;

    typedef struct packed {
        logic                ok;
        logic [SCALED_W-1:0] scaled;
        logic [QUOT_W-1:0]   quot;
        logic [3:0]          wsum;
    } rdjd_s2_t;

    typedef struct packed {
        logic              ok;
        logic [QUOT_W-1:0] quot;
        logic [8:0]        doy0;
        logic [3:0]        wsum;
    } rdjd_s3_t;

    typedef struct packed {
        logic        valid_res;
        logic [15:0] year;
        logic        leap_year;
        logic [2:0]  weekday;
        logic [8:0]  day_of_year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
    } rdjd_res_t;

    // zero-based month index of a zero-based day of year
    function automatic logic [3:0] month_index(logic [8:0] doy0, logic leap);
        logic [3:0] m;
        logic [8:0] cum;
        m = 4'd0;
        for (int k = 0; k < 12; k++)
        begin
            cum = MONTH_START[k] + ((k >= 2) ? {8'd0, leap} : 9'd0);
            if (doy0 >= cum)
            begin
                m = 4'(k);
            end
        end
        return m;
    endfunction

endpackage

// ----- rtl/core/rdjd_day_if.sv -----
// channel interfaces: day number in, julian date out
interface rdjd_day_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] day_number;

    modport source (output valid, output day_number, input ready);
    modport sink (input valid, input day_number, output ready);
endinterface

interface rdjd_date_if;
    logic               valid;
    logic               ready;
    logic               valid_res;
    logic signed [15:0] year;
    logic               leap_year;
    logic [2:0]         weekday;
    logic [8:0]         day_of_year;
    logic [3:0]         month;
    logic [4:0]         day_of_month;

    modport source (output valid, output valid_res, output year, output leap_year,
                    output weekday, output day_of_year, output month,
                    output day_of_month, input ready);
    modport sink (input valid, input valid_res, input year, input leap_year,
                  input weekday, input day_of_year, input month,
                  input day_of_month, output ready);
endinterface

// ----- rtl/core/rdjd_front.sv -----
// first stage: scaling, year range check and weekday digit sum
module rdjd_front (
    input  logic             clk,
    input  logic             rst_n,
    rdjd_day_if.sink         day_in,
    output logic             s1_valid,
    output rdjd_pkg::rdjd_s1_t s1_data,
    input  logic             s1_ready
);
    import rdjd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    rdjd_s1_t   data_reg;
    rdjd_s1_t   data_next;
    logic [34:0] scaled_full;
    logic [6:0] digit_sum;
    logic       advance;

    assign advance      = !valid_reg || s1_ready;
    assign day_in.ready = advance;
    assign s1_valid     = valid_reg;
    assign s1_data      = data_reg;

    always_comb
    begin
        scaled_full = {day_in.day_number[31], day_in.day_number, 2'b00} + 35'(SCALE_OFFSET);
        // 8 = 1 mod 7, so octal digits add up to the residue; 2**32 = 4 mod 7
        digit_sum = {5'd0, day_in.day_number[31:30]};
        for (int i = 0; i < 10; i++)
        begin
            digit_sum = digit_sum + {4'd0, day_in.day_number[3*i +: 3]};
        end
        digit_sum = digit_sum + (day_in.day_number[31] ? 7'd3 : 7'd0) + 7'd6;
        data_next.ok     = !scaled_full[34] && (scaled_full[33:0] < 34'(SCALE_SPAN));
        data_next.scaled = scaled_full[SCALED_W-1:0];
        data_next.wsum   = digit_sum;
        valid_next       = advance ? day_in.valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && day_in.valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- rtl/core/rdjd_div.sv -----
// two stages: reciprocal multiply for the year, then remainder for the day of year
module rdjd_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s1_valid,
    input  rdjd_pkg::rdjd_s1_t s1_data,
    output logic               s1_ready,
    output logic               s3_valid,
    output rdjd_pkg::rdjd_s3_t s3_data,
    input  logic               s3_ready
);
    import rdjd_pkg::*;

    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    rdjd_s2_t             s2_reg;
    rdjd_s2_t             s2_next;
    logic                 s3_valid_reg;
    logic                 s3_valid_next;
    rdjd_s3_t             s3_reg;
    rdjd_s3_t             s3_next;
    logic [PROD_W-1:0]    product;
    logic [SCALED_W-1:0]  back_mult;
    logic [REM_W-1:0]     remainder;
    logic                 adv2;
    logic                 adv3;

    assign adv3     = !s3_valid_reg || s3_ready;
    assign adv2     = !s2_valid_reg || adv3;
    assign s1_ready = adv2;
    assign s3_valid = s3_valid_reg;
    assign s3_data  = s3_reg;

    always_comb
    begin
        product        = {{RECIP_W{1'b0}}, s1_data.scaled} * PROD_W'(RECIP);
        s2_next.ok     = s1_data.ok;
        s2_next.scaled = s1_data.scaled;
        s2_next.quot   = product[RECIP_SHIFT +: QUOT_W];
        s2_next.wsum   = {1'b0, s1_data.wsum[2:0]} + {1'b0, s1_data.wsum[5:3]}
                       + {3'd0, s1_data.wsum[6]};
        s2_valid_next  = adv2 ? s1_valid : s2_valid_reg;

        back_mult      = SCALED_W'(s2_reg.quot) * SCALED_W'(QUARTER_YEAR);
        remainder      = REM_W'(s2_reg.scaled - back_mult);
        s3_next.ok     = s2_reg.ok;
        s3_next.quot   = s2_reg.quot;
        s3_next.doy0   = remainder[REM_W-1:2];
        s3_next.wsum   = {1'b0, s2_reg.wsum[2:0]} + {3'd0, s2_reg.wsum[3]};
        s3_valid_next  = adv3 ? s2_valid_reg : s3_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid)
        begin
            s2_reg <= s2_next;
        end
        if (adv3 && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
    end

endmodule

// ----- rtl/core/rdjd_cal.sv -----
// last stage: month lookup, weekday finish and output register
module rdjd_cal (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s3_valid,
    input  rdjd_pkg::rdjd_s3_t s3_data,
    output logic               s3_ready,
    rdjd_date_if.source        date_out
);
    import rdjd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    rdjd_res_t  res_reg;
    rdjd_res_t  res_next;
    logic       leap;
    logic [3:0] m;
    logic [8:0] cum;
    logic [3:0] wmod;
    logic       advance;

    assign advance  = !valid_reg || date_out.ready;
    assign s3_ready = advance;

    always_comb
    begin
        leap = (s3_data.quot[1:0] == 2'b00);
        m    = month_index(s3_data.doy0, leap);
        cum  = MONTH_START[m] + ((m >= 4'd2) ? {8'd0, leap} : 9'd0);
        wmod = (s3_data.wsum >= 4'd7) ? (s3_data.wsum - 4'd7) : s3_data.wsum;
        res_next = '0;
        if (s3_data.ok)
        begin
            // year = quot - 32768
            res_next.valid_res    = 1'b1;
            res_next.year         = {~s3_data.quot[15], s3_data.quot[14:0]};
            res_next.leap_year    = leap;
            res_next.weekday      = wmod[2:0] + 3'd1;
            res_next.day_of_year  = s3_data.doy0 + 9'd1;
            res_next.month        = m + 4'd1;
            res_next.day_of_month = 5'(s3_data.doy0 - cum) + 5'd1;
        end
        valid_next = advance ? s3_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s3_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign date_out.valid        = valid_reg;
    assign date_out.valid_res    = res_reg.valid_res;
    assign date_out.year         = $signed(res_reg.year);
    assign date_out.leap_year    = res_reg.leap_year;
    assign date_out.weekday      = res_reg.weekday;
    assign date_out.day_of_year  = res_reg.day_of_year;
    assign date_out.month        = res_reg.month;
    assign date_out.day_of_month = res_reg.day_of_month;

endmodule

// ----- rtl/core/rdn_to_julian_date.sv -----
// top level of the rata die to julian calendar date converter
// day_in carries a signed 32-bit day number (day 1 = gregorian 1 january of
// year 1); date_out carries the proleptic julian date: year, leap flag, iso
// weekday, day of year, month and day of month, plus valid_res, which is 0
// with all other fields 0 when the year does not fit 16-bit signed.
// an item is taken when valid and ready are both high on a rising clk.
// an item reaches date_out through the register stages below; one item is
// accepted per cycle unless date_out stalls, and results follow input order.
// the pipeline is four register stages: scaling and range check, the
// 27x28 reciprocal multiply that gives the year, the remainder multiply
// that gives the day of year, and the month table with the output register.
// every stage moves on when it is empty or the next one takes its item, so
// bubbles fill up while date_out is stalled and nothing is dropped; with
// ready low on date_out the block holds up to four items, then drops ready.
// rst_n clears all valid bits at once; the data registers are not reset.
module rdn_to_julian_date (
    input  logic        clk,
    input  logic        rst_n,
    rdjd_day_if.sink    day_in,
    rdjd_date_if.source date_out
);
    import rdjd_pkg::*;

    logic     s1_valid;
    rdjd_s1_t s1_data;
    logic     s1_ready;
    logic     s3_valid;
    rdjd_s3_t s3_data;
    logic     s3_ready;

    rdjd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .day_in   (day_in),
        .s1_valid (s1_valid),
        .s1_data  (s1_data),
        .s1_ready (s1_ready)
    );

    rdjd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_data  (s1_data),
        .s1_ready (s1_ready),
        .s3_valid (s3_valid),
        .s3_data  (s3_data),
        .s3_ready (s3_ready)
    );

    rdjd_cal u_cal (
        .clk      (clk),
        .rst_n    (rst_n),
        .s3_valid (s3_valid),
        .s3_data  (s3_data),
        .s3_ready (s3_ready),
        .date_out (date_out)
    );

endmodule

// ----- rtl/core/rdjd_checker.sv -----
// port-level checks of the converter and their binding to the top level
module rdjd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic               valid_res,
    input logic signed [15:0] year,
    input logic               leap_year,
    input logic [2:0]         weekday,
    input logic [8:0]         day_of_year,
    input logic [3:0]         month,
    input logic [4:0]         day_of_month
);

    // no item is shown while in reset
    assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // a stalled item stays on the port
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // out-of-range years give all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !valid_res |-> (year == 16'sd0) && !leap_year && (weekday == 3'd0)
            && (day_of_year == 9'd0) && (month == 4'd0) && (day_of_month == 5'd0))
        else $error("fields not zero for out-of-range year");

    // leap flag agrees with the year, and date fields lie in range
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && valid_res |-> (leap_year == (year[1:0] == 2'b00))
            && (weekday != 3'd0) && (month != 4'd0) && (month <= 4'd12)
            && (day_of_month != 5'd0) && (day_of_year != 9'd0)
            && (day_of_year <= (leap_year ? 9'd366 : 9'd365)))
        else $error("inconsistent date fields");

endmodule

bind rdn_to_julian_date rdjd_checker u_rdjd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (date_out.valid),
    .res_ready    (date_out.ready),
    .valid_res    (date_out.valid_res),
    .year         (date_out.year),
    .leap_year    (date_out.leap_year),
    .weekday      (date_out.weekday),
    .day_of_year  (date_out.day_of_year),
    .month        (date_out.month),
    .day_of_month (date_out.day_of_month)
);

// ----- tb/tb_rdn_to_julian_date.sv -----
// testbench of the day number to julian date converter: directed and random items checked
module tb_rdn_to_julian_date;

    localparam int DAYS_PER_CYCLE = 1461;
    localparam int FIRST_VALID_DAY = -11968879;
    localparam int LAST_VALID_DAY = 11968144;
    localparam int PIPE_DEPTH = 4;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic               valid_res;
        logic signed [15:0] year;
        logic               leap_year;
        logic [2:0]         weekday;
        logic [8:0]         day_of_year;
        logic [3:0]         month;
        logic [4:0]         day_of_month;
    } julian_date_t;

    typedef struct packed {
        logic signed [31:0] day_number;
        julian_date_t       date;
    } pending_date_t;

    logic clk;
    logic rst_n;

    rdjd_day_if  day_if ();
    rdjd_date_if date_if ();

    rdn_to_julian_date dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .day_in   (day_if),
        .date_out (date_if)
    );

    pending_date_t pending_dates[$];
    int            mismatch_count;
    int            cycle_count;
    int            sink_stall_pct;
    int            sink_hold;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // first day of a zero-based month, counted from zero
    function automatic int month_base(int mon, logic leap);
        int base;
        case (mon)
            0:       base = 0;
            1:       base = 31;
            2:       base = 59;
            3:       base = 90;
            4:       base = 120;
            5:       base = 151;
            6:       base = 181;
            7:       base = 212;
            8:       base = 243;
            9:       base = 273;
            10:      base = 304;
            default: base = 334;
        endcase
        if (mon >= 2 && leap)
        begin
            base = base + 1;
        end
        return base;
    endfunction

    function automatic julian_date_t predict_julian_date(logic signed [31:0] dn);
        julian_date_t d;
        longint       scaled;
        longint       elapsed;
        longint       rem;
        longint       yr;
        longint       wk;
        int           doy0;
        int           mon;
        d = '0;
        scaled = 4 * longint'(dn) + 7;
        elapsed = scaled / DAYS_PER_CYCLE;
        rem = scaled % DAYS_PER_CYCLE;
        // floor division for negative day numbers
        if (rem < 0)
        begin
            rem = rem + DAYS_PER_CYCLE;
            elapsed = elapsed - 1;
        end
        yr = elapsed + 1;
        if (yr < -32768 || yr > 32767)
        begin
            return d;
        end
        wk = (longint'(dn) - 1) % 7;
        if (wk < 0)
        begin
            wk = wk + 7;
        end
        doy0 = int'(rem >>> 2);
        d.leap_year = (yr[1:0] == 2'b00);
        mon = 0;
        for (int k = 0; k < 12; k++)
        begin
            if (doy0 >= month_base(k, d.leap_year))
            begin
                mon = k;
            end
        end
        d.valid_res = 1'b1;
        d.year = yr[15:0];
        d.weekday = 3'(wk + 1);
        d.day_of_year = 9'(doy0 + 1);
        d.month = 4'(mon + 1);
        d.day_of_month = 5'(doy0 - month_base(mon, d.leap_year) + 1);
        return d;
    endfunction

    function automatic logic signed [31:0] random_day();
        int pick;
        int edge_day;
        pick = $urandom_range(0, 9);
        if (pick < 5)
        begin
            return FIRST_VALID_DAY + int'($urandom_range(0, LAST_VALID_DAY - FIRST_VALID_DAY));
        end
        else if (pick < 7)
        begin
            return $urandom;
        end
        else if (pick == 7)
        begin
            edge_day = ($urandom_range(0, 1) == 1) ? LAST_VALID_DAY : FIRST_VALID_DAY;
            return edge_day + int'($urandom_range(0, 6000)) - 3000;
        end
        else
        begin
            return int'($urandom_range(0, 20000)) - 10000;
        end
    endfunction

    // inputs driven at the falling edge; returns at the edge that takes the item
    task automatic send_day(logic signed [31:0] dn);
        @(negedge clk);
        day_if.valid <= 1'b1;
        day_if.day_number <= dn;
        @(posedge clk);
        while (!day_if.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic idle_source(int cycles);
        @(negedge clk);
        day_if.valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_for_results();
        while (pending_dates.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random_days(int count, int gap_pct);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < gap_pct)
            begin
                idle_source($urandom_range(1, 16));
            end
            send_day(random_day());
        end
    endtask

    task automatic test_field_extremes();
        send_day(32'sh8000_0000);
        send_day(32'sh7fff_ffff);
        send_day(32'sh8000_0001);
        send_day(32'sh7fff_fffe);
        send_day(0);
        send_day(1);
        send_day(-1);
    endtask

    task automatic test_year_range_edges();
        send_day(FIRST_VALID_DAY - 1);
        send_day(FIRST_VALID_DAY);
        send_day(LAST_VALID_DAY);
        send_day(LAST_VALID_DAY + 1);
    endtask

    task automatic test_leap_calendar();
        // year 4 begins at day 1094, year 5 at day 1460
        send_day(1094);
        send_day(1124);
        send_day(1125);
        send_day(1153);
        send_day(1154);
        send_day(1459);
        send_day(1518);
        send_day(1519);
        send_day(1824);
    endtask

    task automatic test_weekdays();
        for (int dn = 2; dn <= 7; dn++)
        begin
            send_day(dn);
        end
    endtask

    task automatic test_drain_pause();
        send_random_days(20, 0);
        idle_source(1);
        wait_for_results();
        send_random_days(20, 0);
    endtask

    task automatic test_random_both_idle();
        sink_stall_pct = 10;
        send_random_days(700, 15);
    endtask

    task automatic test_random_backpressure();
        sink_stall_pct = 25;
        send_random_days(600, 3);
    endtask

    task automatic test_random_full_rate();
        sink_stall_pct = 0;
        send_random_days(600, 0);
    endtask

    // output ready with random stall bursts
    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
        end
        else if ($urandom_range(0, 99) < sink_stall_pct)
        begin
            date_if.ready <= 1'b0;
            sink_hold <= $urandom_range(0, 15);
        end
        else
        begin
            date_if.ready <= 1'b1;
        end
    end

    // record each taken item first, then check the result of the same edge
    always @(posedge clk)
    begin
        julian_date_t  got;
        pending_date_t want;
        if (rst_n)
        begin
            if (day_if.valid && day_if.ready)
            begin
                pending_dates.push_back({day_if.day_number,
                                         predict_julian_date(day_if.day_number)});
            end
            if (date_if.valid && date_if.ready)
            begin
                got.valid_res = date_if.valid_res;
                got.year = date_if.year;
                got.leap_year = date_if.leap_year;
                got.weekday = date_if.weekday;
                got.day_of_year = date_if.day_of_year;
                got.month = date_if.month;
                got.day_of_month = date_if.day_of_month;
                if (pending_dates.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("unexpected date item: valid_res=%0d year=%0d",
                                 got.valid_res, got.year);
                    end
                end
                else
                begin
                    want = pending_dates.pop_front();
                    if (got !== want.date)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("day %0d: expected v=%0d y=%0d l=%0d w=%0d d=%0d m=%0d dm=%0d",
                                     want.day_number, want.date.valid_res, want.date.year,
                                     want.date.leap_year, want.date.weekday,
                                     want.date.day_of_year, want.date.month,
                                     want.date.day_of_month);
                            $display("         got      v=%0d y=%0d l=%0d w=%0d d=%0d m=%0d dm=%0d",
                                     got.valid_res, got.year, got.leap_year, got.weekday,
                                     got.day_of_year, got.month, got.day_of_month);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        day_if.valid = 1'b0;
        day_if.day_number = '0;
        date_if.ready = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        sink_stall_pct = 10;
        sink_hold = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_year_range_edges();
        test_leap_calendar();
        test_weekdays();
        test_drain_pause();
        test_random_both_idle();
        test_random_backpressure();
        test_random_full_rate();
        idle_source(1);

        wait_for_results();
        repeat (PIPE_DEPTH * 4) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
